/* design/mptb_pkg.sv */
// ----------------------------------------------------------------------------
// mptb_pkg: shared types and codes of the modular power table builder
// Function codes, status codes and the multiplier handshake structs.
// ----------------------------------------------------------------------------
package mptb_pkg;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_LADDER = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_NOSTART = 2'd2
  } status_t;

  // Handshake between the sequencer and the modular multiplier.
  typedef struct packed {
    logic go;
  } mm_ctl_t;

  typedef struct packed {
    logic done;
  } mm_sts_t;

endpackage

/* design/mptb_mulmod.sv */
// ----------------------------------------------------------------------------
// mptb_mulmod: bit-serial modular multiplier
// Double-and-add over the multiplier bits, one bit per cycle; operands are
// first reduced by a bit-serial restoring remainder.
// ----------------------------------------------------------------------------
module mptb_mulmod import mptb_pkg::*; #(
  parameter int VALUE_BITS = 62
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mm_ctl_t               ctl,
  input  logic [VALUE_BITS-1:0] a,
  input  logic [VALUE_BITS-1:0] b,
  input  logic [VALUE_BITS-1:0] p,
  output mm_sts_t               sts,
  output logic [VALUE_BITS-1:0] result
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_REDA = 5'b00010,
    S_REDB = 5'b00100,
    S_MUL  = 5'b01000,
    S_DONE = 5'b10000
  } mm_state_t;

  mm_state_t             state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] a_r, a_nxt, b_r, b_nxt, p_r, p_nxt;
  logic [VALUE_BITS-1:0] src_r, src_nxt, acc_r, acc_nxt;
  logic [VALUE_BITS:0]   sh, dbl, add;
  logic                  small_p;

  assign small_p = (p_r < VALUE_BITS'(2));
  // Shared step: shift in a source bit (remainder) or double (product).
  assign sh  = {acc_r, src_r[VALUE_BITS-1]};
  assign dbl = {acc_r, 1'b0};
  assign add = ((dbl >= {1'b0, p_r}) ? dbl - {1'b0, p_r} : dbl) + {1'b0, a_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    p_nxt     = p_r;
    src_nxt   = src_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.go) begin
          a_nxt     = a;
          b_nxt     = b;
          p_nxt     = p;
          src_nxt   = a;
          acc_nxt   = '0;
          cnt_nxt   = CW'(VALUE_BITS);
          state_nxt = S_REDA;
        end
      end
      S_REDA, S_REDB: begin
        acc_nxt = (sh >= {1'b0, p_r}) ? VALUE_BITS'(sh - {1'b0, p_r})
                                      : VALUE_BITS'(sh);
        src_nxt = {src_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          cnt_nxt = CW'(VALUE_BITS);
          acc_nxt = '0;
          if (state_r == S_REDA) begin
            a_nxt     = acc_nxt;
            src_nxt   = b_r;
            state_nxt = S_REDB;
          end else begin
            src_nxt   = acc_nxt;
            state_nxt = S_MUL;
          end
          // Remainder of last step must use the computed value.
          if (state_r == S_REDA)
            a_nxt = (sh >= {1'b0, p_r}) ? VALUE_BITS'(sh - {1'b0, p_r})
                                        : VALUE_BITS'(sh);
          else
            src_nxt = (sh >= {1'b0, p_r}) ? VALUE_BITS'(sh - {1'b0, p_r})
                                          : VALUE_BITS'(sh);
        end
      end
      S_MUL: begin
        if (src_r[VALUE_BITS-1])
          acc_nxt = (add >= {1'b0, p_r}) ? VALUE_BITS'(add - {1'b0, p_r})
                                         : VALUE_BITS'(add);
        else
          acc_nxt = (dbl >= {1'b0, p_r}) ? VALUE_BITS'(dbl - {1'b0, p_r})
                                         : VALUE_BITS'(dbl);
        src_nxt = {src_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1))
          state_nxt = S_DONE;
      end
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    p_r   <= p_nxt;
    src_r <= src_nxt;
    acc_r <= acc_nxt;
  end

  assign sts.done = (state_r == S_DONE);
  assign result   = small_p ? '0 : acc_r;

endmodule

/* design/modular_power_table_builder.sv */
// ----------------------------------------------------------------------------
// modular_power_table_builder: table of powers of a base modulo a modulus
// Start fills entries 0..first_run_length by successive modular products;
// ladder steps extend the table; read returns one entry.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in_     | input     | in_valid/in_stall  | func base modulus entry_index
//          |           |                    | last_rung
//  out_    | output    | out_valid/out_stall| index value status run_done
//  cfg_    | input     | cfg_we             | cfg_first_run_length
//
// A modular multiply in the bit-serial multiplier reduces both operands,
// then runs double-and-add. A start costs (first_run_length+1) such
// multiplies counting the base reduction; a ladder step one multiply; a
// read only a table access.
// The table memory is read with a registered port.
// Reset is synchronous and clears control state; the table is not cleared.
// in_stall stays high while a request is in work or its result is waiting;
// a result holds on the output register until out_stall is low.
// ----------------------------------------------------------------------------
module modular_power_table_builder import mptb_pkg::*; #(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_BITS  = 62
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [9:0]            cfg_first_run_length,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic [VALUE_BITS-1:0] in_base,
  input  logic [VALUE_BITS-1:0] in_modulus,
  input  logic [9:0]            in_entry_index,
  input  logic                  in_last_rung,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [10:0]           out_index,
  output logic [VALUE_BITS-1:0] out_value,
  output logic [1:0]            out_status,
  output logic                  out_run_done
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RED   = 7'b0000010,  // reduce base into entry 0
    S_FILL  = 7'b0000100,  // successive products
    S_LRD   = 7'b0001000,  // ladder source read
    S_LMUL  = 7'b0010000,  // ladder product
    S_RRD   = 7'b0100000,  // read entry
    S_OUT   = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [9:0]            lmin_r, lmin_nxt;
  logic [VALUE_BITS-1:0] mod_r, mod_nxt, mult_r, mult_nxt;
  logic [VALUE_BITS-1:0] base0_r, base0_nxt, cur_r, cur_nxt;
  logic                  started_r, started_nxt;
  logic [10:0]           j_r, j_nxt;          // fill index
  logic                  go_r, go_nxt;
  logic [10:0]           dest_r, dest_nxt;
  logic [AW-1:0]         raddr_r, raddr_nxt;

  logic [VALUE_BITS-1:0] mem [TABLE_DEPTH];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;

  mm_ctl_t               mm_ctl;
  mm_sts_t               mm_sts;
  logic [VALUE_BITS-1:0] mm_a, mm_b, mm_res;

  logic [10:0]           o_idx_r, o_idx_nxt;
  logic [VALUE_BITS-1:0] o_val_r, o_val_nxt;
  logic [1:0]            o_st_r, o_st_nxt;
  logic                  o_done_r, o_done_nxt, o_valid_r, o_valid_nxt;
  logic [11:0]           ldest;

  assign ldest = {2'b0, in_entry_index} + {2'b0, lmin_r} + 12'd1;

  mptb_mulmod #(.VALUE_BITS(VALUE_BITS)) u_mm (
    .clk(clk), .rst_n(rst_n), .ctl(mm_ctl), .a(mm_a), .b(mm_b), .p(mod_r),
    .sts(mm_sts), .result(mm_res)
  );

  // Start reduction uses base*1; fill uses cur*base0; ladder uses T[i]*mult.
  always_comb begin
    mm_a = cur_r;
    mm_b = base0_r;
    if (state_r == S_RED) begin
      mm_a = base0_r;
      mm_b = VALUE_BITS'(1);
    end else if (state_r == S_LMUL) begin
      mm_a = rd_data_r;
      mm_b = mult_r;
    end
  end
  assign mm_ctl.go = go_r;

  always_comb begin
    we    = 1'b0;
    waddr = AW'(j_r);
    wdata = mm_res;
    if (mm_sts.done && (state_r == S_RED || state_r == S_FILL)) we = 1'b1;
    if (mm_sts.done && state_r == S_LMUL) begin
      we    = 1'b1;
      waddr = AW'(dest_r);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_data_r <= mem[raddr_r];
  end

  assign in_stall  = (state_r != S_IDLE) || o_valid_r;
  assign out_valid = o_valid_r;
  assign out_index = o_idx_r;
  assign out_value = o_val_r;
  assign out_status = o_st_r;
  assign out_run_done = o_done_r;

  always_comb begin
    state_nxt   = state_r;
    lmin_nxt    = cfg_we ? cfg_first_run_length : lmin_r;
    mod_nxt     = mod_r;
    mult_nxt    = mult_r;
    base0_nxt   = base0_r;
    cur_nxt     = cur_r;
    started_nxt = started_r;
    j_nxt       = j_r;
    go_nxt      = 1'b0;
    dest_nxt    = dest_r;
    raddr_nxt   = raddr_r;
    o_idx_nxt   = o_idx_r;
    o_val_nxt   = o_val_r;
    o_st_nxt    = o_st_r;
    o_done_nxt  = o_done_r;
    // Drop the result once the receiver takes it.
    o_valid_nxt = o_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          o_st_nxt   = ST_OK;
          o_val_nxt  = '0;
          o_done_nxt = 1'b0;
          case (in_func)
            FUNC_START: begin
              if (32'(lmin_r) >= TABLE_DEPTH) begin
                o_idx_nxt   = {1'b0, lmin_r};
                o_st_nxt    = ST_RANGE;
                o_valid_nxt = 1'b1;
              end else begin
                mod_nxt   = in_modulus;
                base0_nxt = in_base;
                j_nxt     = '0;
                go_nxt    = 1'b1;
                state_nxt = S_RED;
              end
            end
            FUNC_LADDER: begin
              o_done_nxt = in_last_rung;
              if (!started_r) begin
                o_idx_nxt   = '0;
                o_st_nxt    = ST_NOSTART;
                o_valid_nxt = 1'b1;
              end else if (32'(in_entry_index) >= TABLE_DEPTH ||
                           32'(ldest) >= TABLE_DEPTH) begin
                o_idx_nxt   = ldest[10:0];
                o_st_nxt    = ST_RANGE;
                o_valid_nxt = 1'b1;
              end else begin
                dest_nxt  = ldest[10:0];
                raddr_nxt = AW'(in_entry_index);
                state_nxt = S_LRD;
              end
            end
            FUNC_READ: begin
              if (!started_r) begin
                o_idx_nxt   = '0;
                o_st_nxt    = ST_NOSTART;
                o_valid_nxt = 1'b1;
              end else if (32'(in_entry_index) >= TABLE_DEPTH) begin
                o_idx_nxt   = {1'b0, in_entry_index};
                o_st_nxt    = ST_RANGE;
                o_valid_nxt = 1'b1;
              end else begin
                o_idx_nxt = {1'b0, in_entry_index};
                raddr_nxt = AW'(in_entry_index);
                state_nxt = S_RRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_RED, S_FILL: begin
        if (mm_sts.done) begin
          if (state_r == S_RED) base0_nxt = mm_res;
          cur_nxt = mm_res;
          if (j_r == {1'b0, lmin_r}) begin
            mult_nxt    = mm_res;
            started_nxt = 1'b1;
            o_idx_nxt   = j_r;
            o_val_nxt   = mm_res;
            o_done_nxt  = 1'b1;
            o_valid_nxt = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            j_nxt     = j_r + 11'd1;
            go_nxt    = 1'b1;
            state_nxt = S_FILL;
          end
        end
      end
      S_LRD: begin
        go_nxt    = 1'b1;
        state_nxt = S_LMUL;
      end
      S_LMUL: begin
        if (mm_sts.done) begin
          o_idx_nxt   = dest_r;
          o_val_nxt   = mm_res;
          o_valid_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_RRD: state_nxt = S_OUT;
      S_OUT: begin
        o_val_nxt   = rd_data_r;
        o_valid_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      lmin_r    <= '0;
      started_r <= 1'b0;
      mod_r     <= '0;
      mult_r    <= '0;
      go_r      <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lmin_r    <= lmin_nxt;
      started_r <= started_nxt;
      mod_r     <= mod_nxt;
      mult_r    <= mult_nxt;
      go_r      <= go_nxt;
      o_valid_r <= o_valid_nxt;
    end
    base0_r  <= base0_nxt;
    cur_r    <= cur_nxt;
    j_r      <= j_nxt;
    dest_r   <= dest_nxt;
    raddr_r  <= raddr_nxt;
    o_idx_r  <= o_idx_nxt;
    o_val_r  <= o_val_nxt;
    o_st_r   <= o_st_nxt;
    o_done_r <= o_done_nxt;
  end

endmodule

/* verif/tb_modular_power_table_builder.sv */
// ----------------------------------------------------------------------------
// tb_modular_power_table_builder: self-checking bench of the power table
// Drives start, ladder, read and unused requests with random gaps, predicts
// every result from a local copy of the table and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_modular_power_table_builder;
  import mptb_pkg::*;

  localparam int DEPTH = 1024;
  localparam int VBITS = 62;
  localparam logic [VBITS-1:0] VMAX = {VBITS{1'b1}};

  typedef struct {
    func_t            func;
    logic [VBITS-1:0] base;
    logic [VBITS-1:0] modulus;
    logic [9:0]       idx;
    logic             last;
  } req_t;

  typedef struct {
    logic [10:0]      idx;
    logic [VBITS-1:0] value;
    status_t          status;
    logic             done;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [9:0] cfg_first_run_length = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [VBITS-1:0] in_base = '0;
  logic [VBITS-1:0] in_modulus = '0;
  logic [9:0] in_entry_index = '0;
  logic in_last_rung = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [10:0] out_index;
  logic [VBITS-1:0] out_value;
  logic [1:0] out_status;
  logic out_run_done;

  modular_power_table_builder u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_first_run_length(cfg_first_run_length),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_base(in_base), .in_modulus(in_modulus),
    .in_entry_index(in_entry_index), .in_last_rung(in_last_rung),
    .out_valid(out_valid), .out_stall(out_stall), .out_index(out_index),
    .out_value(out_value), .out_status(out_status), .out_run_done(out_run_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Requests waiting to be driven, and results the table predicts.
  req_t pending_reqs[$];
  res_t expected_results[$];
  int fail_cnt = 0;
  int send_idle_pct = 23;
  int recv_idle_pct = 46;

  // Predicted block state.
  logic [VBITS-1:0] pred_table [DEPTH];
  logic [VBITS-1:0] pred_modulus = '0;
  logic [VBITS-1:0] pred_multiplier = '0;
  logic pred_started = 1'b0;
  logic [9:0] pred_frl = '0;

  // Generator view: which entries a request may safely read.
  logic gen_written [DEPTH];
  int gen_wlist[$];
  logic gen_started = 1'b0;
  logic [9:0] gen_frl = '0;

  function automatic logic [VBITS-1:0] mod_mult(logic [VBITS-1:0] a, logic [VBITS-1:0] b,
                                                logic [VBITS-1:0] p);
    logic [2*VBITS-1:0] prod;
    if (p < 2) return '0;
    prod = (a % p) * (b % p);
    return VBITS'(prod % p);
  endfunction

  // Advance the predicted state by one accepted request.
  function automatic void predict_power_result(req_t r);
    res_t e;
    logic [10:0] dest;
    int j;
    dest = {1'b0, r.idx} + {1'b0, pred_frl} + 11'd1;
    e.done = 1'b0;
    case (r.func)
      FUNC_START: begin
        pred_modulus = r.modulus;
        pred_table[0] = (r.modulus < 2) ? '0 : r.base % r.modulus;
        for (j = 0; j < pred_frl; j++)
          pred_table[j+1] = mod_mult(pred_table[j], pred_table[0], r.modulus);
        pred_multiplier = pred_table[pred_frl];
        pred_started = 1'b1;
        e = '{idx: {1'b0, pred_frl}, value: pred_multiplier, status: ST_OK, done: 1'b1};
      end
      FUNC_LADDER: begin
        if (!pred_started)
          e = '{idx: '0, value: '0, status: ST_NOSTART, done: r.last};
        else if (dest >= DEPTH)
          e = '{idx: dest, value: '0, status: ST_RANGE, done: r.last};
        else begin
          pred_table[dest] = mod_mult(pred_table[r.idx], pred_multiplier, pred_modulus);
          e = '{idx: dest, value: pred_table[dest], status: ST_OK, done: r.last};
        end
      end
      FUNC_READ: begin
        if (!pred_started)
          e = '{idx: '0, value: '0, status: ST_NOSTART, done: 1'b0};
        else
          e = '{idx: {1'b0, r.idx}, value: pred_table[r.idx], status: ST_OK, done: 1'b0};
      end
      default: return;  // unused code: no result
    endcase
    expected_results.push_back(e);
  endfunction

  function automatic void mark_written(int k);
    if (!gen_written[k]) begin
      gen_written[k] = 1'b1;
      gen_wlist.push_back(k);
    end
  endfunction

  // Queue one request and track which entries it writes.
  function automatic void queue_req(func_t f, logic [VBITS-1:0] b, logic [VBITS-1:0] m,
                                    logic [9:0] i, logic l);
    req_t r;
    int dest;
    r = '{func: f, base: b, modulus: m, idx: i, last: l};
    dest = int'(i) + int'(gen_frl) + 1;
    if (f == FUNC_START) begin
      for (int j = 0; j <= gen_frl; j++) mark_written(j);
      gen_started = 1'b1;
    end else if (f == FUNC_LADDER && gen_started && dest < DEPTH)
      mark_written(dest);
    pending_reqs.push_back(r);
  endfunction

  function automatic logic [VBITS-1:0] rand_val();
    return VBITS'({$urandom, $urandom});
  endfunction

  function automatic logic [9:0] pick_written();
    return 10'(gen_wlist[$urandom_range(gen_wlist.size()-1)]);
  endfunction

  // One random request: mostly well-formed ladder runs over written entries.
  function automatic void queue_random_req(logic allow_start);
    int sel;
    logic [VBITS-1:0] m;
    logic [9:0] i;
    sel = $urandom_range(99);
    if (allow_start && sel < 12) begin
      case ($urandom_range(9))
        0: m = 62'($urandom_range(3));
        1: m = rand_val() & ~62'd1;
        default: m = rand_val() | 62'd1;
      endcase
      queue_req(FUNC_START, rand_val(), m, 10'($urandom), 1'($urandom));
    end else if (sel < 65) begin
      i = 10'($urandom);
      if (gen_started && int'(i) + int'(gen_frl) + 1 < DEPTH && !gen_written[i] &&
          $urandom_range(9) != 0)
        i = pick_written();
      if (gen_started && int'(i) + int'(gen_frl) + 1 < DEPTH && !gen_written[i])
        i = 10'(DEPTH - 1);
      queue_req(FUNC_LADDER, rand_val(), rand_val(), i, 1'($urandom_range(7) == 0));
    end else if (sel < 95) begin
      i = gen_started ? pick_written() : 10'($urandom);
      queue_req(FUNC_READ, rand_val(), rand_val(), i, 1'($urandom));
    end else
      queue_req(FUNC_NONE, rand_val(), rand_val(), 10'($urandom), 1'($urandom));
  endfunction

  // Driver: hold the request until accepted, then advance with random gaps.
  always @(posedge clk) begin
    logic nxt_valid;
    req_t r;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        r.func = func_t'(in_func);
        r.base = in_base;
        r.modulus = in_modulus;
        r.idx = in_entry_index;
        r.last = in_last_rung;
        predict_power_result(r);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && pending_reqs.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        r = pending_reqs.pop_front();
        in_func <= r.func;
        in_base <= r.base;
        in_modulus <= r.modulus;
        in_entry_index <= r.idx;
        in_last_rung <= r.last;
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  // Monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0)
        report_mismatch("unexpected result index", 64'(out_index), 64'd0);
      else begin
        e = expected_results.pop_front();
        if (out_index !== e.idx) report_mismatch("index", 64'(out_index), 64'(e.idx));
        if (out_value !== e.value) report_mismatch("value", 64'(out_value), 64'(e.value));
        if (out_status !== e.status)
          report_mismatch("status", 64'(out_status), 64'(e.status));
        if (out_run_done !== e.done)
          report_mismatch("run_done", 64'(out_run_done), 64'(e.done));
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Wait for the block to drain, then let an unused request finish too.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_frl(logic [9:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_first_run_length <= v;
    pred_frl = v;
    gen_frl = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [9:0] phase_frl [8];
    logic one_start;
    phase_frl = '{10'd1023, 10'd7, 10'd0, 10'd2, 10'd12, 10'd5, 10'd1, 10'd3};
    for (int k = 0; k < DEPTH; k++) begin
      gen_written[k] = 1'b0;
      pred_table[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: no start yet, unused code, modulus corner cases, range error.
    write_frl(10'd0);
    queue_req(FUNC_LADDER, VMAX, VMAX, 10'd1023, 1'b1);
    queue_req(FUNC_READ, '0, '0, 10'd0, 1'b0);
    queue_req(FUNC_NONE, VMAX, VMAX, 10'd1023, 1'b1);
    queue_req(FUNC_START, VMAX, 62'd0, '0, 1'b0);
    queue_req(FUNC_START, VMAX, 62'd1, '0, 1'b0);
    queue_req(FUNC_START, 62'd7, 62'd2, '0, 1'b0);
    queue_req(FUNC_START, '0, VMAX, '0, 1'b0);
    queue_req(FUNC_START, VMAX, VMAX - 62'd2, 10'd1023, 1'b1);
    queue_req(FUNC_LADDER, '0, '0, 10'd0, 1'b0);
    queue_req(FUNC_LADDER, '0, '0, 10'd1, 1'b1);
    queue_req(FUNC_LADDER, '0, '0, 10'd1023, 1'b0);
    queue_req(FUNC_READ, '0, '0, 10'd2, 1'b0);
    wait_idle();
    write_frl(10'd3);
    // Register changed after start: new destination, latched multiplier.
    queue_req(FUNC_LADDER, '0, '0, 10'd0, 1'b0);
    queue_req(FUNC_READ, '0, '0, 10'd4, 1'b1);
    queue_req(FUNC_START, 62'h2AAA_AAAA_AAAA_AAAA, 62'h1555_5555_5555_5555, '0, 1'b0);
    queue_req(FUNC_LADDER, '0, '0, 10'd3, 1'b1);
    queue_req(FUNC_READ, '0, '0, 10'd7, 1'b0);
    wait_idle();

    // Random phases; the full-length start is run once only.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 23;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_frl(phase_frl[ph]);
      one_start = (phase_frl[ph] == 10'd1023);
      queue_req(FUNC_START, rand_val(), rand_val() | 62'd1, '0, 1'b0);
      for (int n = 0; n < 55; n++) queue_random_req(!one_start);
      wait_idle();
    end

    repeat (300) @(posedge clk);
    if (fail_cnt == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #60ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
